// ===== rtl/tso_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture subresource offset package
// Shared constants, controller state type, command and status structs, and
// the reciprocal table used for the ceiling block count.
// ----------------------------------------------------------------------------
package tso_pkg;

  localparam int MAX_LEVELS = 15;
  localparam int DIM_BITS   = 14;

  localparam int LVL_W = $clog2(MAX_LEVELS + 1);
  localparam int CMP_W = (LVL_W > 4) ? LVL_W : 4;

  localparam int DW    = DIM_BITS + 1;
  localparam int SAT_W = (DW > 15) ? DW : 15;

  localparam int REC_K = DW + 4;
  localparam int REC_W = REC_K + 1;

  localparam int A_W = DW + 8;
  localparam int P_W = A_W + DW;
  localparam int Q_W = P_W + 12;

  localparam logic [REC_W-1:0] REC_ONE = REC_W'(1) << REC_K;
  localparam logic [SAT_W-1:0] DIM_TOP = SAT_W'(1) << DIM_BITS;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEVEL = 2'd1;
  localparam logic [1:0] ST_LAYER = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_DRAIN,
    S_MUL,
    S_FIN
  } tso_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic mul;
    logic commit;
  } tso_cmd_t;

  typedef struct packed {
    logic early;
    logic last;
    logic busy;
  } tso_stat_t;

  // Rounded-up reciprocal of a block dimension, scaled by two to the REC_K.
  function automatic logic [REC_W-1:0] recip(input logic [3:0] b);
    logic [REC_W-1:0] m;
    unique case (b)
      4'd2:    m = REC_W'((REC_ONE + 1) / 2);
      4'd3:    m = REC_W'((REC_ONE + 2) / 3);
      4'd4:    m = REC_W'((REC_ONE + 3) / 4);
      4'd5:    m = REC_W'((REC_ONE + 4) / 5);
      4'd6:    m = REC_W'((REC_ONE + 5) / 6);
      4'd7:    m = REC_W'((REC_ONE + 6) / 7);
      4'd8:    m = REC_W'((REC_ONE + 7) / 8);
      4'd9:    m = REC_W'((REC_ONE + 8) / 9);
      4'd10:   m = REC_W'((REC_ONE + 9) / 10);
      4'd11:   m = REC_W'((REC_ONE + 10) / 11);
      4'd12:   m = REC_W'((REC_ONE + 11) / 12);
      4'd13:   m = REC_W'((REC_ONE + 12) / 13);
      4'd14:   m = REC_W'((REC_ONE + 13) / 14);
      4'd15:   m = REC_W'((REC_ONE + 14) / 15);
      default: m = REC_ONE;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/texture_subresource_offset_top.sv =====
// ----------------------------------------------------------------------------
// Texture subresource offset top level
// Places one mip level of one array layer inside a packed texture.
// ----------------------------------------------------------------------------
// One query is taken at a time. A query with an out-of-range level or layer,
// or with an unknown format, skips the walk and goes from the range check
// straight to the commit. Otherwise the walk issues one mip level per cycle
// into a four-stage sizing pipeline, for L levels where L is the level count
// after clamping, and the array pitch multiply and the commit follow the
// drain. A new query is accepted once the previous one is committed, even
// while its result still waits in the output register.
module texture_subresource_offset_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [14:0] tex_width,
  input  logic [14:0] tex_height,
  input  logic [11:0] tex_depth,
  input  logic [3:0]  level_count,
  input  logic [11:0] layer_count,
  input  logic [3:0]  wanted_level,
  input  logic [10:0] wanted_layer,
  input  logic        format_known,
  input  logic [3:0]  blk_width,
  input  logic [3:0]  blk_height,
  input  logic [4:0]  blk_bytes,
  input  logic [7:0]  texel_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] sub_offset,
  output logic [31:0] sub_size,
  output logic [31:0] row_bytes,
  output logic [31:0] slice_bytes,
  output logic [31:0] layer_bytes,
  output logic [1:0]  status
);

  tso_pkg::tso_cmd_t  cmd;
  tso_pkg::tso_stat_t st;

  tso_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  tso_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .tex_width    (tex_width),
    .tex_height   (tex_height),
    .tex_depth    (tex_depth),
    .level_count  (level_count),
    .layer_count  (layer_count),
    .wanted_level (wanted_level),
    .wanted_layer (wanted_layer),
    .format_known (format_known),
    .blk_width    (blk_width),
    .blk_height   (blk_height),
    .blk_bytes    (blk_bytes),
    .texel_bits   (texel_bits),
    .sub_offset   (sub_offset),
    .sub_size     (sub_size),
    .row_bytes    (row_bytes),
    .slice_bytes  (slice_bytes),
    .layer_bytes  (layer_bytes),
    .status       (status)
  );

endmodule

// ===== rtl/tso_ctrl.sv =====
// ----------------------------------------------------------------------------
// Texture subresource offset controller
// Sequences one query: load, range check, level walk, pipeline drain,
// array pitch multiply and commit into the output register.
// ----------------------------------------------------------------------------
module tso_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tso_pkg::tso_stat_t st,
  output tso_pkg::tso_cmd_t  cmd
);

  tso_pkg::tso_state_t state, state_next;
  logic out_valid_next;
  logic slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tso_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tso_pkg::S_IDLE: begin
        if (in_valid) state_next = tso_pkg::S_CHECK;
      end
      tso_pkg::S_CHECK: begin
        state_next = st.early ? tso_pkg::S_FIN : tso_pkg::S_WALK;
      end
      tso_pkg::S_WALK: begin
        if (st.last) state_next = tso_pkg::S_DRAIN;
      end
      tso_pkg::S_DRAIN: begin
        if (!st.busy) state_next = tso_pkg::S_MUL;
      end
      tso_pkg::S_MUL: begin
        state_next = tso_pkg::S_FIN;
      end
      tso_pkg::S_FIN: begin
        if (slot_free) state_next = tso_pkg::S_IDLE;
      end
      default: begin
        state_next = tso_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = (state != tso_pkg::S_IDLE);
    cmd.load   = (state == tso_pkg::S_IDLE) && in_valid;
    cmd.issue  = (state == tso_pkg::S_WALK);
    cmd.mul    = (state == tso_pkg::S_MUL);
    cmd.commit = (state == tso_pkg::S_FIN) && slot_free;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("Commit while a result is still stalled.");

  a_rose_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("Output valid rose without a commit.");

  a_mul_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> !st.busy)
    else $error("Array pitch multiply while the pipeline is busy.");

endmodule

// ===== rtl/tso_dp.sv =====
// ----------------------------------------------------------------------------
// Texture subresource offset datapath
// Holds the query, sizes one mip level per issue through a four-stage
// pipeline, accumulates the chain size and forms the registered result.
// ----------------------------------------------------------------------------
module tso_dp (
  input  logic               clk,
  input  logic               rst,
  input  tso_pkg::tso_cmd_t  cmd,
  output tso_pkg::tso_stat_t st,
  input  logic [14:0]        tex_width,
  input  logic [14:0]        tex_height,
  input  logic [11:0]        tex_depth,
  input  logic [3:0]         level_count,
  input  logic [11:0]        layer_count,
  input  logic [3:0]         wanted_level,
  input  logic [10:0]        wanted_layer,
  input  logic               format_known,
  input  logic [3:0]         blk_width,
  input  logic [3:0]         blk_height,
  input  logic [4:0]         blk_bytes,
  input  logic [7:0]         texel_bits,
  output logic [31:0]        sub_offset,
  output logic [31:0]        sub_size,
  output logic [31:0]        row_bytes,
  output logic [31:0]        slice_bytes,
  output logic [31:0]        layer_bytes,
  output logic [1:0]         status
);

  localparam int DW    = tso_pkg::DW;
  localparam int SAT_W = tso_pkg::SAT_W;
  localparam int LVL_W = tso_pkg::LVL_W;
  localparam int CMP_W = tso_pkg::CMP_W;
  localparam int REC_K = tso_pkg::REC_K;
  localparam int REC_W = tso_pkg::REC_W;
  localparam int A_W   = tso_pkg::A_W;
  localparam int P_W   = tso_pkg::P_W;
  localparam int Q_W   = tso_pkg::Q_W;
  localparam int M_W   = DW + REC_W;

  // Query registers.
  logic [DW-1:0]    w, h;
  logic [11:0]      d;
  logic [LVL_W-1:0] levels, idx;
  logic [3:0]       wanted;
  logic [10:0]      lay;
  logic [3:0]       bw_m1, bh_m1;
  logic [4:0]       bb;
  logic [7:0]       bits;
  logic             comp;
  logic [REC_W-1:0] m_w, m_h;
  logic             early;
  logic [1:0]       early_code;

  logic [DW-1:0]    w_sat, h_sat;
  logic [3:0]       bwid, bhgt, lc1;
  logic [LVL_W-1:0] lc;
  logic [11:0]      layers1;
  logic             lvl_bad, lay_bad;

  always_comb begin
    w_sat   = (SAT_W'(tex_width) > tso_pkg::DIM_TOP) ? DW'(tso_pkg::DIM_TOP)
                                                      : DW'(tex_width);
    h_sat   = (SAT_W'(tex_height) > tso_pkg::DIM_TOP) ? DW'(tso_pkg::DIM_TOP)
                                                       : DW'(tex_height);
    bwid    = (blk_width == 4'd0) ? 4'd1 : blk_width;
    bhgt    = (blk_height == 4'd0) ? 4'd1 : blk_height;
    lc1     = (level_count == 4'd0) ? 4'd1 : level_count;
    lc      = (CMP_W'(lc1) > CMP_W'(tso_pkg::MAX_LEVELS)) ? LVL_W'(tso_pkg::MAX_LEVELS)
                                                            : LVL_W'(lc1);
    layers1 = (layer_count == 12'd0) ? 12'd1 : layer_count;
    lvl_bad = CMP_W'(wanted_level) >= CMP_W'(lc);
    lay_bad = {1'b0, wanted_layer} >= layers1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w          <= w_sat;
      h          <= h_sat;
      d          <= tex_depth;
      levels     <= lc;
      idx        <= '0;
      wanted     <= wanted_level;
      lay        <= wanted_layer;
      bw_m1      <= bwid - 4'd1;
      bh_m1      <= bhgt - 4'd1;
      bb         <= blk_bytes;
      bits       <= texel_bits;
      comp       <= (bwid > 4'd1) || (bhgt > 4'd1);
      m_w        <= tso_pkg::recip(bwid);
      m_h        <= tso_pkg::recip(bhgt);
      early      <= lvl_bad || lay_bad || !format_known;
      early_code <= lvl_bad ? tso_pkg::ST_LEVEL
                  : (lay_bad ? tso_pkg::ST_LAYER : tso_pkg::ST_OK);
    end else if (cmd.issue) begin
      w   <= w >> 1;
      h   <= h >> 1;
      d   <= d >> 1;
      idx <= idx + LVL_W'(1);
    end
  end

  // Stage A: reciprocal products for the ceiling block counts.
  logic            va, hit_a;
  logic [M_W-1:0]  qw_a, qh_a;
  logic [DW-1:0]   w1_a, h1_a;
  logic [11:0]     d1_a;
  logic [DW-1:0]   xw, xh;

  assign xw = w + DW'(bw_m1);
  assign xh = h + DW'(bh_m1);

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      qw_a  <= M_W'(xw) * M_W'(m_w);
      qh_a  <= M_W'(xh) * M_W'(m_h);
      w1_a  <= (w == '0) ? DW'(1) : w;
      h1_a  <= (h == '0) ? DW'(1) : h;
      d1_a  <= (d == 12'd0) ? 12'd1 : d;
      hit_a <= (CMP_W'(idx) == CMP_W'(wanted));
    end
  end

  // Stage B: row quantity in bits or bytes, and row count.
  logic           vb, hit_b;
  logic [A_W-1:0] a_b;
  logic [DW-1:0]  h_b;
  logic [11:0]    d_b;
  logic [DW-1:0]  nbw, nbh;

  always_comb begin
    nbw = qw_a[REC_K +: DW];
    nbh = qh_a[REC_K +: DW];
    if (nbw == '0) nbw = DW'(1);
    if (nbh == '0) nbh = DW'(1);
  end

  always_ff @(posedge clk) begin
    if (va) begin
      a_b   <= comp ? A_W'(nbw) * A_W'(bb) : A_W'(w1_a) * A_W'(bits);
      h_b   <= comp ? nbh : h1_a;
      d_b   <= d1_a;
      hit_b <= hit_a;
    end
  end

  // Stage C: slice products.
  logic           vc, hit_c;
  logic [P_W-1:0] p_c, s_c;
  logic [A_W-1:0] row_c;
  logic [11:0]    d_c;

  always_ff @(posedge clk) begin
    if (vb) begin
      p_c   <= P_W'(a_b) * P_W'(h_b);
      s_c   <= P_W'(a_b >> 3) * P_W'(h_b);
      row_c <= comp ? a_b : (a_b >> 3);
      d_c   <= d_b;
      hit_c <= hit_b;
    end
  end

  // Stage D: level size.
  logic           vd, hit_d;
  logic [Q_W-1:0] size_d, q_c;
  logic [P_W-1:0] slice_d;
  logic [A_W-1:0] row_d;

  assign q_c = Q_W'(p_c) * Q_W'(d_c);

  always_ff @(posedge clk) begin
    if (vc) begin
      size_d  <= comp ? q_c : (q_c >> 3);
      slice_d <= comp ? p_c : s_c;
      row_d   <= row_c;
      hit_d   <= hit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= cmd.issue;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  // Chain accumulation; big marks a sum that no longer fits 32 bits.
  logic [31:0] run, off, sz_s, row_s, slice_s;
  logic        big;
  logic [32:0] sum;
  logic        size_hi;

  assign sum     = {1'b0, run} + {1'b0, size_d[31:0]};
  assign size_hi = size_d > Q_W'(32'hFFFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      run <= '0;
      big <= 1'b0;
    end else if (vd) begin
      run <= sum[31:0];
      big <= big || size_hi || sum[32];
    end
  end

  always_ff @(posedge clk) begin
    if (vd && hit_d) begin
      off     <= run;
      sz_s    <= size_d[31:0];
      row_s   <= 32'(row_d);
      slice_s <= 32'(slice_d);
    end
  end

  logic [42:0] prod;
  logic [43:0] total;
  logic        ovf;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 43'(lay) * 43'(run);
    end
  end

  assign total = 44'(off) + 44'(prod);
  assign ovf   = big || (total > 44'h0_FFFF_FFFF);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (early || ovf) begin
        sub_offset  <= '0;
        sub_size    <= '0;
        row_bytes   <= '0;
        slice_bytes <= '0;
        layer_bytes <= '0;
        status      <= early ? early_code : tso_pkg::ST_OVF;
      end else begin
        sub_offset  <= total[31:0];
        sub_size    <= sz_s;
        row_bytes   <= row_s;
        slice_bytes <= slice_s;
        layer_bytes <= run;
        status      <= tso_pkg::ST_OK;
      end
    end
  end

  assign st.early = early;
  assign st.last  = (idx == levels - LVL_W'(1));
  assign st.busy  = va || vb || vc || vd;

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({va && hit_a, vb && hit_b, vc && hit_c, vd && hit_d}))
    else $error("More than one requested level in the pipeline.");

  a_commit_drained: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !early) |-> !st.busy)
    else $error("Commit before the level pipeline drained.");

  a_issue_checked: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !early)
    else $error("Level walk started for a query that ends early.");

endmodule
